// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the turn control block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge of clk outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge of clk outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dwtc_pkg.sv =====
// Constants, codes and the arctangent table of the differential wheel turn control.
package dwtc_pkg;

  // CORDIC configuration.
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int GUARD_BITS   = 16;
  localparam int ATAN_SH      = 32 - ANGLE_BITS;
  localparam int ANG_SH       = ANGLE_BITS - 16;

  // Datapath widths.
  localparam int XW  = 36;               // x and y with guard bits, signed
  localparam int ZW  = ANGLE_BITS + 2;   // angle accumulator, signed
  localparam int MAW = XW - 17;          // multiplier operand a
  localparam int MBW = 30;               // multiplier operand b
  localparam int PW  = MAW + MBW;        // product

  // 1/K in Q30.
  localparam logic [MBW-1:0] INV_GAIN = 30'd652032874;

  // Steering mode codes.
  localparam logic [1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [1:0] MODE_SOFT     = 2'd1;
  localparam logic [1:0] MODE_HARD     = 2'd2;
  localparam logic [1:0] MODE_RSVD     = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_HARD     = 2'd0;
  localparam logic [1:0] REG_SOFT     = 2'd1;
  localparam logic [1:0] REG_STRAIGHT = 2'd2;
  localparam logic [1:0] REG_TOP      = 2'd3;

  // atan(2^-i) with 2^32 units per full circle.
  localparam logic [31:0] ATAN_FULL [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81
  };

  // Arctangent entry rounded to the nearest unit of the CORDIC angle scale.
  function automatic logic [ANGLE_BITS-1:0] atan_units(input logic [4:0] i);
    logic [32:0] t;
    t = {1'b0, ATAN_FULL[i]} + (33'd1 << (ATAN_SH - 1));
    return ANGLE_BITS'(t >> ATAN_SH);
  endfunction

endpackage

// ===== sv/differential_wheel_turn_control.sv =====
// Top level of the differential wheel turn control: heading vector to wheel speeds.
//
// A heading vector (heading_x, heading_y, signed Q8.8) enters as one transaction on the
// s_axis channel. The block finds its angle and length with an iterative vectoring
// CORDIC, clamps the length to top_speed, advances the straight/soft/hard hysteresis
// mode and returns one transaction on m_axis with both wheel speeds and the new mode.
// Thresholds and top speed are written through the APB port; the user must write them
// only while the block is idle, and the block itself does not enforce this.
//
// Sequence: the CORDIC performs one micro-rotation per cycle (16 iterations), the length
// scaling takes two passes of a shared 19x30 multiplier, and a soft turn adds one multiply
// and a restoring divider. The result is registered in the final step; s_axis_tready
// returns in the cycle after. One item is worked on at a time.
// The result sits in an output register, so the next item may be accepted while it
// waits; if the receiver still holds off when the next result is ready, the sequencer
// waits in its final step. Reset restores the register defaults and straight mode.
`include "assert_macros.svh"

module differential_wheel_turn_control
  import dwtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input heading: [15:0] heading_x, [31:16] heading_y.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // Result: [16:0] left_speed, [33:17] right_speed, [35:34] turn_mode, [39:36] zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sequencer states.
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_ROT   = 10'b00_0000_0010,
    ST_MUL0  = 10'b00_0000_0100,
    ST_MUL1  = 10'b00_0000_1000,
    ST_LEN   = 10'b00_0001_0000,
    ST_MODE  = 10'b00_0010_0000,
    ST_SMUL  = 10'b00_0100_0000,
    ST_DIVLD = 10'b00_1000_0000,
    ST_DIV   = 10'b01_0000_0000,
    ST_FIN   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [14:0] hard_thr, soft_thr, straight_thr, top_speed;

  // Working registers.
  logic [1:0]         steering_mode;
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic               zero_vec;
  logic [ITER_W-1:0]  iter;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      acc;
  logic [15:0]        len;
  logic signed [15:0] ang;
  logic [14:0]        base;
  logic [14:0]        num;
  logic [30:0]        dq;
  logic [14:0]        rem;
  logic [4:0]         div_cnt;

  // Output register.
  logic signed [16:0] out_left, out_right;
  logic [1:0]         out_mode;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes are decoded on the word index only.
  // ---------------------------------------------------------------------------
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hard_thr     <= 15'd16384;
      soft_thr     <= 15'd12743;
      straight_thr <= 15'd1820;
      top_speed    <= 15'd2560;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HARD:     hard_thr     <= pwdata[14:0];
        REG_SOFT:     soft_thr     <= pwdata[14:0];
        REG_STRAIGHT: straight_thr <= pwdata[14:0];
        REG_TOP:      top_speed    <= pwdata[14:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HARD:     prdata = {17'd0, hard_thr};
      REG_SOFT:     prdata = {17'd0, soft_thr};
      REG_STRAIGHT: prdata = {17'd0, straight_thr};
      REG_TOP:      prdata = {17'd0, top_speed};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input decode and quadrant pre-rotation into the right half-plane.
  // ---------------------------------------------------------------------------
  logic               in_acc;
  logic signed [XW-1:0] xi, yi, x_pre, y_pre;
  logic signed [ZW-1:0] z_pre;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign xi = XW'($signed(s_axis_tdata[15:0])) <<< GUARD_BITS;
  assign yi = XW'($signed(s_axis_tdata[31:16])) <<< GUARD_BITS;

  always_comb begin
    x_pre = xi;
    y_pre = yi;
    z_pre = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        x_pre = yi;
        y_pre = -xi;
        z_pre = QUARTER;
      end else begin
        x_pre = -yi;
        y_pre = xi;
        z_pre = -QUARTER;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC micro-rotation, one per cycle.
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] datan;

  assign dx    = y >>> iter;
  assign dy    = x >>> iter;
  assign datan = $signed({2'b00, atan_units(5'(iter))});

  // Angle reduced to the 16-bit binary angle scale.
  logic signed [ZW+15:0] z_ext;
  logic signed [15:0]    ang_red;

  assign z_ext = (ZW + 16)'(z);

  generate
    if (ANG_SH > 0) begin : g_round
      logic signed [ZW+15:0] z_rnd;
      assign z_rnd   = (z_ext + ((ZW + 16)'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
      assign ang_red = z_rnd[15:0];
    end else begin : g_scale
      logic signed [ZW+15:0] z_scl;
      assign z_scl   = z_ext <<< (-ANG_SH);
      assign ang_red = z_scl[15:0];
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Shared multiplier: two partial products of x * 1/K, then base * numerator.
  // ---------------------------------------------------------------------------
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [PW+16:0] len_sum;

  always_comb begin
    mul_a = MAW'(x[16:0]);
    mul_b = INV_GAIN;
    priority case (1'b1)
      state == ST_MUL1: mul_a = x[XW-1:17];
      state == ST_SMUL: begin
        mul_a = MAW'(num);
        mul_b = MBW'(base);
      end
      default: ;
    endcase
  end

  assign len_sum = (PW + 17)'(acc) + {prod, 17'd0}
                 + ((PW + 17)'(1) << (29 + GUARD_BITS));

  // ---------------------------------------------------------------------------
  // Hysteresis cascade on |angle|.
  // ---------------------------------------------------------------------------
  logic [16:0] mag;
  logic [14:0] base_cl;
  logic [1:0]  mode_new;
  logic [14:0] num_new;

  assign mag     = ang[15] ? 17'(-$signed({ang[15], ang})) : {1'b0, ang};
  assign base_cl = (len < {1'b0, top_speed}) ? len[14:0] : top_speed;
  assign num_new = (mag <= {2'b0, hard_thr}) ? 15'(17'(hard_thr) - mag) : 15'd0;

  always_comb begin
    mode_new = steering_mode;
    if (mode_new == MODE_HARD) begin
      if (mag <= {2'b0, soft_thr}) mode_new = MODE_SOFT;
    end
    if (mode_new == MODE_SOFT) begin
      if (mag > {2'b0, hard_thr})          mode_new = MODE_HARD;
      else if (mag <= {2'b0, straight_thr}) mode_new = MODE_STRAIGHT;
    end
    if (mode_new == MODE_STRAIGHT) begin
      if (mag > {2'b0, hard_thr})          mode_new = MODE_HARD;
      else if (mag > {2'b0, straight_thr}) mode_new = MODE_SOFT;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider step.
  // ---------------------------------------------------------------------------
  logic [15:0] trial;
  logic        qbit;

  assign trial = {rem, dq[30]};
  assign qbit  = (trial >= {1'b0, hard_thr});

  // ---------------------------------------------------------------------------
  // Wheel speeds from mode, base speed and turning direction.
  // ---------------------------------------------------------------------------
  logic signed [16:0] s1, s2;
  logic               out_load;

  always_comb begin
    unique case (steering_mode)
      MODE_SOFT: begin
        s1 = $signed({1'b0, dq[15:0]});
        s2 = $signed({1'b0, base, 1'b0}) - $signed({1'b0, dq[15:0]});
      end
      MODE_HARD: begin
        s1 = -$signed({2'b00, top_speed});
        s2 = $signed({2'b00, top_speed});
      end
      default: begin
        s1 = $signed({2'b00, base});
        s2 = $signed({2'b00, base});
      end
    endcase
  end

  assign out_load = (state == ST_FIN) && (!m_axis_tvalid || m_axis_tready);

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = ST_ROT;
      ST_ROT:   if (iter == ITER_W'(CORDIC_ITERS - 1)) state_next = ST_MUL0;
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_LEN;
      ST_LEN:   state_next = ST_MODE;
      ST_MODE: begin
        if (mode_new == MODE_SOFT && hard_thr != 15'd0) state_next = ST_SMUL;
        else                                           state_next = ST_FIN;
      end
      ST_SMUL:  state_next = ST_DIVLD;
      ST_DIVLD: state_next = ST_DIV;
      ST_DIV:   if (div_cnt == 5'd30) state_next = ST_FIN;
      ST_FIN:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      steering_mode <= MODE_STRAIGHT;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MODE) steering_mode <= mode_new;
      if (out_load)          m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x        <= x_pre;
        y        <= y_pre;
        z        <= z_pre;
        zero_vec <= (s_axis_tdata[31:0] == 32'd0);
        iter     <= '0;
      end
      ST_ROT: begin
        if (!y[XW-1]) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + datan;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - datan;
        end
        iter <= iter + ITER_W'(1);
      end
      ST_MUL0: prod <= mul_a * mul_b;
      ST_MUL1: begin
        acc  <= prod;
        prod <= mul_a * mul_b;
      end
      ST_LEN: begin
        len <= zero_vec ? 16'd0 : len_sum[46 + GUARD_BITS - 16 +: 16];
        ang <= zero_vec ? 16'sd0 : ang_red;
      end
      ST_MODE: begin
        base <= base_cl;
        num  <= num_new;
        dq   <= '0;
      end
      ST_SMUL: prod <= mul_a * mul_b;
      ST_DIVLD: begin
        dq      <= prod[30:0] + 31'(hard_thr >> 1);
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem     <= qbit ? 15'(trial - {1'b0, hard_thr}) : trial[14:0];
        dq      <= {dq[29:0], qbit};
        div_cnt <= div_cnt + 5'd1;
      end
      ST_FIN: begin
        if (out_load) begin
          out_left  <= (ang > 0) ? s1 : s2;
          out_right <= (ang > 0) ? s2 : s1;
          out_mode  <= steering_mode;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {4'd0, out_mode, out_right, out_left};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_mode_code, m_axis_tvalid, out_mode != MODE_RSVD, "reserved turn mode sent")
  `ASSERT_IMPLIES(a_hard_opposite, m_axis_tvalid && out_mode == MODE_HARD, out_left == -out_right, "hard turn speeds not opposite")
  `ASSERT_IMPLIES(a_straight_equal, m_axis_tvalid && out_mode == MODE_STRAIGHT, out_left == out_right, "straight speeds differ")
  `ASSERT_NEXT(a_mode_hold, state != ST_MODE, $stable(steering_mode), "mode changed outside mode step")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the differential wheel turn control block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dwtc_pkg::*;

  // Overall cycle budget.
  localparam int RUN_LIMIT = 2_000_000;
  // Length of the deliberate receiver hold-off, far longer than one soft-turn item.
  localparam int HOLD_CYCLES = 400;
  // Settling time after the final result, a little above the soft-turn latency.
  localparam int DRAIN_CYCLES = 64;
  // Fractional guard bits that the CORDIC keeps on x and y.
  localparam int GUARD = 16;
  // Inverse CORDIC gain, 1/K in Q30.
  localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;

  // One expected or observed result transaction, unpacked into its fields.
  typedef struct packed {
    logic [16:0] left_spd;
    logic [16:0] right_spd;
    logic [1:0]  mode;
  } wheel_speeds_t;

  // Back-pressure styles that the result receiver cycles through.
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] heading_x, [31:16] heading_y
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [16:0] left, [33:17] right, [35:34] mode
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // The testbench's own copy of the configuration and of the hysteresis state.
  // The copies start from the register defaults and are updated on every write.
  logic [14:0] hard_thr     = 15'd16384;
  logic [14:0] soft_thr     = 15'd12743;
  logic [14:0] straight_thr = 15'd1820;
  logic [14:0] top_spd      = 15'd2560;
  logic [1:0]  steer_mode   = MODE_STRAIGHT;

  // Headings waiting to be offered, and wheel speeds still owed by the block.
  logic [31:0]   heading_q[$];
  wheel_speeds_t wheel_exp_q[$];
  wheel_speeds_t seen_res;
  wheel_speeds_t want_res;

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_left = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [2:0] beat = '0;

  differential_wheel_turn_control dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Every mismatch passes through here: it is printed on one line and counted.
  task automatic report_mismatch(input string what, input longint got_v, input longint exp_v);
    fail_cnt++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, exp_v);
  endtask

  // atan(2^-k) with 2^32 units to the full circle.
  function automatic longint arc_full(input int k);
    case (k)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10680862;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      default: return 81;
    endcase
  endfunction

  // Works out the wheel speeds for one accepted heading, advances the mode
  // copy and queues the result that the block owes for it.
  task automatic predict_wheels(input logic signed [15:0] hx, input logic signed [15:0] hy);
    longint cx, cy, cz, tmp, arc, angle, s1, s2, lft, rgt;
    longint unsigned ux, len, mag, base, h, num, prod;
    int k, steps, zsh, ash;
    wheel_speeds_t r;
    cx = longint'(hx) * 65536;
    cy = longint'(hy) * 65536;
    angle = 0;
    len = 0;
    // A zero vector has neither angle nor length.
    if (cx != 0 || cy != 0) begin
      cz = 0;
      // Vectors in the left half plane are first turned by a quarter circle.
      if (cx < 0) begin
        tmp = cx;
        if (cy >= 0) begin
          cx = cy;
          cy = -tmp;
          cz = longint'(1) <<< (ANGLE_BITS - 2);
        end else begin
          cx = -cy;
          cy = tmp;
          cz = -(longint'(1) <<< (ANGLE_BITS - 2));
        end
      end
      steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
      ash = 32 - ANGLE_BITS;
      for (k = 0; k < steps; k++) begin
        arc = (arc_full(k) + (longint'(1) <<< (ash - 1))) >>> ash;
        tmp = cx;
        if (cy >= 0) begin
          cx = cx + (cy >>> k);
          cy = cy - (tmp >>> k);
          cz += arc;
        end else begin
          cx = cx - (cy >>> k);
          cy = cy + (tmp >>> k);
          cz -= arc;
        end
      end
      // Bring the angle to the 16-bit scale; an angle of pi wraps to -32768.
      zsh = ANGLE_BITS - 16;
      if (zsh > 0) begin
        cz = (cz + (longint'(1) <<< (zsh - 1))) >>> zsh;
      end else if (zsh < 0) begin
        cz = cz <<< (-zsh);
      end
      angle = longint'($signed(cz[15:0]));
      ux = cx;
      len = (ux * INV_GAIN_Q30 + (64'd1 << (29 + GUARD))) >> (30 + GUARD);
    end

    mag = (angle < 0) ? -angle : angle;
    base = (len < top_spd) ? len : top_spd;

    // The hysteresis cascades: hard may relax to soft, soft may then go either
    // way, and straight may then engage again, all within one item.
    if (steer_mode == MODE_HARD) begin
      if (mag <= soft_thr) steer_mode = MODE_SOFT;
    end
    if (steer_mode == MODE_SOFT) begin
      if (mag > hard_thr) steer_mode = MODE_HARD;
      else if (mag <= straight_thr) steer_mode = MODE_STRAIGHT;
    end
    if (steer_mode == MODE_STRAIGHT) begin
      if (mag > hard_thr) steer_mode = MODE_HARD;
      else if (mag > straight_thr) steer_mode = MODE_SOFT;
    end

    if (steer_mode == MODE_SOFT) begin
      h = hard_thr;
      num = (mag <= h) ? h - mag : 0;
      prod = (h != 0) ? (base * num + h / 2) / h : 0;
      s1 = longint'(prod);
      s2 = longint'(2 * base) - s1;
    end else if (steer_mode == MODE_HARD) begin
      s1 = -longint'(top_spd);
      s2 = longint'(top_spd);
    end else begin
      s1 = longint'(base);
      s2 = longint'(base);
    end

    // A positive angle turns left; otherwise the wheels swap roles.
    if (angle > 0) begin
      lft = s1;
      rgt = s2;
    end else begin
      lft = s2;
      rgt = s1;
    end
    r.left_spd = lft[16:0];
    r.right_spd = rgt[16:0];
    r.mode = steer_mode;
    wheel_exp_q.push_back(r);
  endtask

  // Sender. Headings leave the queue in bursts of random length separated by
  // random gaps; a burst with no gap at all is common, so back-to-back
  // transactions occur as well.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (heading_q.size() != 0) begin
        s_axis_tdata <= heading_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. It changes its back-pressure style whenever its stall count runs out and,
  // when asked, holds off entirely for a long stretch so that the block backs
  // up and refuses further headings.
  always @(posedge clk) begin
    beat <= beat + 3'd1;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        stall_left <= $urandom_range(20, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_style)
        STALL_NONE:  m_axis_tready <= 1'b1;
        STALL_LIGHT: m_axis_tready <= ($urandom_range(0, 9) < 7);
        STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 9) < 2);
        default:     m_axis_tready <= (beat < 3'd3);
      endcase
    end
  end

  // Monitor. A result is matched against the oldest expectation before any
  // heading accepted at the same edge adds a new one.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_res.left_spd = m_axis_tdata[16:0];
        seen_res.right_spd = m_axis_tdata[33:17];
        seen_res.mode = m_axis_tdata[35:34];
        if (wheel_exp_q.size() == 0) begin
          report_mismatch("result with nothing owed", longint'(m_axis_tdata), 0);
        end else begin
          want_res = wheel_exp_q.pop_front();
          if (seen_res.left_spd !== want_res.left_spd) begin
            report_mismatch("left_speed", $signed(seen_res.left_spd),
                            $signed(want_res.left_spd));
          end
          if (seen_res.right_spd !== want_res.right_spd) begin
            report_mismatch("right_speed", $signed(seen_res.right_spd),
                            $signed(want_res.right_spd));
          end
          if (seen_res.mode !== want_res.mode) begin
            report_mismatch("turn_mode", seen_res.mode, want_res.mode);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_wheels(s_axis_tdata[15:0], s_axis_tdata[31:16]);
      end
    end
  end

  // Watchdog: a hung block ends the run here.
  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic push_heading(input int hx, input int hy);
    heading_q.push_back({hy[15:0], hx[15:0]});
  endtask

  function automatic int extreme_value();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return int'($urandom);
    endcase
  endfunction

  // Queues a random mix of headings. Most of them are sweeps, in which a fixed
  // x and a steadily moving y swing the angle through the thresholds so that
  // the hysteresis is driven both up and down; the rest are unrelated vectors
  // of full range, short vectors with components within +/-3000, and extreme components.
  task automatic queue_random(input int n);
    int added, run_len, span, hx, hy, dy, pick;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        run_len = $urandom_range(8, 40);
        span = $urandom_range(64, 30000);
        hx = int'($urandom_range(0, 2 * span)) - span;
        dy = (2 * span) / run_len + 1;
        hy = ($urandom_range(0, 1) != 0) ? -span : span;
        if (hy > 0) dy = -dy;
        repeat (run_len) begin
          push_heading(hx, hy);
          hy += dy;
        end
        added += run_len;
      end else if (pick < 6) begin
        push_heading(int'($urandom), int'($urandom));
        added++;
      end else if (pick < 8) begin
        push_heading(int'($urandom_range(0, 6000)) - 3000, int'($urandom_range(0, 6000)) - 3000);
        added++;
      end else begin
        push_heading(extreme_value(), extreme_value());
        added++;
      end
    end
  endtask

  // Returns once every queued heading has been accepted and every owed result
  // has arrived. Sampled at the falling edge, clear of the driving edge.
  task automatic wait_drained();
    do @(negedge clk);
    while (heading_q.size() != 0 || s_axis_tvalid || wheel_exp_q.size() != 0);
  endtask

  // One register write: setup cycle, then access cycle. The register takes the
  // value at the edge that ends the access cycle. The upper bits of the write
  // data carry noise, which the block must mask off.
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {17'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HARD:     hard_thr = value;
      REG_SOFT:     soft_thr = value;
      REG_STRAIGHT: straight_thr = value;
      default:      top_spd = value;
    endcase
  endtask

  task automatic apply_settings(input logic [14:0] hard_v, input logic [14:0] soft_v,
                                input logic [14:0] straight_v, input logic [14:0] top_v);
    repeat (4) @(posedge clk);
    write_reg(REG_HARD, hard_v);
    write_reg(REG_SOFT, soft_v);
    write_reg(REG_STRAIGHT, straight_v);
    write_reg(REG_TOP, top_v);
  endtask

  // Stimulus sequence.
  initial begin
    int h_v, s_v, st_v;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed headings under the reset configuration. The zero vector must
    // give straight driving at zero speed.
    push_heading(0, 0);
    push_heading(256, 0);
    // Largest components on each axis; a vector pointing straight back has an
    // angle of pi, which reads as the most negative angle.
    push_heading(32767, 0);
    push_heading(-32768, 0);
    push_heading(0, 32767);
    push_heading(0, -32768);
    push_heading(32767, 32767);
    push_heading(-32768, -32768);
    push_heading(32767, -32768);
    push_heading(-32768, 32767);
    // Soft turns to either side, about thirty degrees.
    push_heading(1000, 577);
    push_heading(1000, -577);
    // Hysteresis walk: engage hard, stay hard just above the soft threshold,
    // relax to soft, stay soft, relax to straight, re-engage soft, and remain
    // soft just below the hard threshold.
    push_heading(-100, 1000);
    push_heading(174, 985);
    push_heading(500, 866);
    push_heading(940, 342);
    push_heading(996, 87);
    push_heading(940, -342);
    push_heading(87, -996);
    // The smallest vectors in each direction.
    push_heading(1, 0);
    push_heading(-1, 0);
    push_heading(0, 1);
    push_heading(0, -1);
    push_heading(1, 1);
    push_heading(-1, -1);
    wait_drained();

    // Random phases, each under its own configuration. Between phases the
    // sender pauses until the block has returned every result.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        // A zero hard threshold: every non-zero angle turns hard.
        0: apply_settings(15'd0, 15'd0, 15'd0, 15'd32767);
        1: apply_settings(15'd16384, 15'd12743, 15'd1820, 15'd2560);
        // Only an angle of pi exceeds the largest hard threshold.
        2: apply_settings(15'd32767, 15'd32767, 15'd0, 15'd32767);
        // Zero top speed with the straight threshold above the soft one.
        3: apply_settings(15'd32767, 15'd0, 15'd32767, 15'd0);
        // Thresholds in the wrong order; the cascade applies as written.
        4: apply_settings(15'd2000, 15'd20000, 15'd8000, 15'd5000);
        6: apply_settings(15'd8192, 15'd4096, 15'd1024, 15'd32767);
        8: apply_settings(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
        default: begin
          h_v = $urandom_range(0, 32767);
          s_v = $urandom_range(0, h_v);
          st_v = $urandom_range(0, s_v);
          apply_settings(15'(h_v), 15'(s_v), 15'(st_v), 15'($urandom));
        end
      endcase
      queue_random(200);
      // In two phases the receiver stops for a long while as soon as the
      // headings start flowing, so the block fills and stalls its input.
      if (ph == 1 || ph == 5) begin
        @(posedge clk);
        hold_req <= hold_req + 1;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== differential_wheel_turn_control.f =====
+incdir+sv
sv/dwtc_pkg.sv
sv/differential_wheel_turn_control.sv
sim/tb_top.sv
